[hw/rtl/csi_pkg.sv]
// Package for the control sequence parser: result types, character codes
// and result queue sizing. No dependencies.
package csi_pkg;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] MARK_LO   = 8'h3C;
  localparam logic [7:0] MARK_HI   = 8'h3F;
  localparam logic [7:0] INTER_LO  = 8'h20;
  localparam logic [7:0] INTER_HI  = 8'h2F;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] FINAL_HI  = 8'h7F;

  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic        item_kind;
    logic [3:0]  param_index;
    logic [2:0]  sub_index;
    logic [15:0] param_value;
    logic        param_absent;
    logic [6:0]  final_byte;
    logic [7:0]  marker_byte;
    logic [7:0]  intermediate_byte;
    logic [4:0]  param_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[hw/rtl/csi_if.sv]
// Valid/ready channel interfaces for the parser's input bytes and results.
// No dependencies.
interface csi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_sequence;

  modport source (output valid, output data_byte, output start_of_sequence, input ready);
  modport sink (input valid, input data_byte, input start_of_sequence, output ready);
endinterface

interface csi_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [3:0]  param_index;
  logic [2:0]  sub_index;
  logic [15:0] param_value;
  logic        param_absent;
  logic [6:0]  final_byte;
  logic [7:0]  marker_byte;
  logic [7:0]  intermediate_byte;
  logic [4:0]  param_count;
  logic        last;

  modport source (output valid, output item_kind, output param_index, output sub_index,
                  output param_value, output param_absent, output final_byte,
                  output marker_byte, output intermediate_byte, output param_count,
                  output last, input ready);
  modport sink (input valid, input item_kind, input param_index, input sub_index,
                input param_value, input param_absent, input final_byte,
                input marker_byte, input intermediate_byte, input param_count,
                input last, output ready);
endinterface

[hw/rtl/csi_sequence_parser.sv]
// Top level of the control sequence parser: input byte register, decode and
// result queue. Depends on csi_pkg, csi_if, csi_decode and csi_result_queue.
//
// The parser takes one byte of a control sequence body per beat and can accept
// a byte in every cycle while the result queue has room. An accepted byte is
// held in an input register and decoded from it once the queue has room for
// two results; its results are then written into the four-entry result queue,
// from whose head the first of them is taken at the output. Most bytes give
// zero or one result; a final byte that also closes a pending parameter within
// the subparameter limit gives two, which leave on consecutive output beats.
// The input side keeps accepting as long as the queue has room for two
// results, so a byte stream runs at one byte per cycle while the output drains
// at least as many results as are produced.
module csi_sequence_parser #(
  parameter int MAX_PARAMS    = 16,
  parameter int VALUE_BITS    = 16,
  parameter int MAX_SUBPARAMS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csi_in_if.sink     in_i,
  csi_out_if.source  out_o
);
  import csi_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_sos_q;
  logic       room;
  logic       advance;
  push_t      push;
  result_t    head;

  assign advance    = in_vld_q && room;
  assign in_i.ready = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_sos_q  <= in_i.start_of_sequence;
    end
  end

  csi_decode #(
    .MAX_PARAMS    (MAX_PARAMS),
    .VALUE_BITS    (VALUE_BITS),
    .MAX_SUBPARAMS (MAX_SUBPARAMS)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (advance),
    .byte_i  (in_byte_q),
    .sos_i   (in_sos_q),
    .push_o  (push)
  );

  csi_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .valid_o (out_o.valid),
    .head_o  (head),
    .room_o  (room)
  );

  assign out_o.item_kind         = head.item_kind;
  assign out_o.param_index       = head.param_index;
  assign out_o.sub_index         = head.sub_index;
  assign out_o.param_value       = head.param_value;
  assign out_o.param_absent      = head.param_absent;
  assign out_o.final_byte        = head.final_byte;
  assign out_o.marker_byte       = head.marker_byte;
  assign out_o.intermediate_byte = head.intermediate_byte;
  assign out_o.param_count       = head.param_count;
  assign out_o.last              = head.last;

endmodule

[hw/rtl/csi_decode.sv]
// Parse state and per-byte decode: turns one registered byte into zero, one
// or two results. Depends on csi_pkg.
module csi_decode #(
  parameter int MAX_PARAMS    = 16,
  parameter int VALUE_BITS    = 16,
  parameter int MAX_SUBPARAMS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [7:0]      byte_i,
  input  logic            sos_i,
  output csi_pkg::push_t  push_o
);
  import csi_pkg::*;

  localparam int PCW = $clog2(MAX_PARAMS + 1);
  localparam int SCW = $clog2(MAX_SUBPARAMS + 2);
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  logic                  in_seq_q, in_seq_d;
  logic                  first_q, first_d;
  logic [PCW-1:0]        pcnt_q, pcnt_d;
  logic [SCW-1:0]        scnt_q, scnt_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  digits_q, digits_d;
  logic                  closed_q, closed_d;
  logic [7:0]            marker_q, marker_d;
  logic [7:0]            inter_q, inter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q <= 1'b0;
      first_q  <= 1'b0;
      pcnt_q   <= '0;
      scnt_q   <= '0;
      acc_q    <= '0;
      digits_q <= 1'b0;
      closed_q <= 1'b0;
      marker_q <= '0;
      inter_q  <= '0;
    end else begin
      in_seq_q <= in_seq_d;
      first_q  <= first_d;
      pcnt_q   <= pcnt_d;
      scnt_q   <= scnt_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
      closed_q <= closed_d;
      marker_q <= marker_d;
      inter_q  <= inter_d;
    end
  end

  always_comb begin
    logic                  cur_first;
    logic [PCW-1:0]        cur_pcnt;
    logic [SCW-1:0]        cur_scnt;
    logic [VALUE_BITS-1:0] cur_acc;
    logic                  present;
    logic                  sub_ok;
    logic [PCW:0]          pcnt_inc;
    logic [VALUE_BITS+3:0] prod;
    logic [31:0]           pidx_ext;
    logic [31:0]           sidx_ext;
    logic [31:0]           acc_ext;
    logic [31:0]           cnt_ext;
    logic                  is_final;
    result_t               elem;
    result_t               cmd;

    in_seq_d = in_seq_q;
    first_d  = first_q;
    pcnt_d   = pcnt_q;
    scnt_d   = scnt_q;
    acc_d    = acc_q;
    digits_d = digits_q;
    closed_d = closed_q;
    marker_d = marker_q;
    inter_d  = inter_q;
    push_o   = '0;
    elem     = '0;
    cmd      = '0;
    cnt_ext  = '0;

    if (valid_i && sos_i) begin
      in_seq_d = 1'b1;
      first_d  = 1'b1;
      pcnt_d   = '0;
      scnt_d   = '0;
      acc_d    = '0;
      digits_d = 1'b0;
      closed_d = 1'b0;
      marker_d = '0;
      inter_d  = '0;
    end

    cur_first = first_d;
    cur_pcnt  = pcnt_d;
    cur_scnt  = scnt_d;
    cur_acc   = acc_d;
    present   = digits_d || (scnt_d != '0);
    sub_ok    = (32'(cur_scnt) <= 32'(MAX_SUBPARAMS));
    pcnt_inc  = {1'b0, cur_pcnt} + (PCW+1)'(1);
    prod      = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1)
                + (VALUE_BITS+4)'(byte_i[3:0]);
    is_final  = (byte_i >= FINAL_LO) && (byte_i <= FINAL_HI);

    pidx_ext = 32'(cur_pcnt);
    sidx_ext = 32'(cur_scnt);
    acc_ext  = 32'(cur_acc);

    elem.item_kind    = KIND_ELEMENT;
    elem.param_index  = pidx_ext[3:0];
    elem.sub_index    = sidx_ext[2:0];
    elem.param_absent = (byte_i == CH_SEMI) && !present;
    elem.param_value  = elem.param_absent ? 16'd0 : acc_ext[15:0];

    if (valid_i && in_seq_d) begin
      first_d = 1'b0;
      if (is_final) begin
        cmd.item_kind         = KIND_COMMAND;
        cmd.final_byte        = byte_i[6:0];
        cmd.marker_byte       = marker_d;
        cmd.intermediate_byte = inter_d;
        cmd.last              = 1'b1;
        if (!closed_d && present) begin
          cnt_ext = 32'(pcnt_inc);
        end else begin
          cnt_ext = 32'(cur_pcnt);
        end
        cmd.param_count = cnt_ext[4:0];
        if (!closed_d && present && sub_ok) begin
          push_o.count  = 2'd2;
          push_o.first  = elem;
          push_o.second = cmd;
        end else begin
          push_o.count = 2'd1;
          push_o.first = cmd;
        end
        in_seq_d = 1'b0;
        pcnt_d   = '0;
        scnt_d   = '0;
        acc_d    = '0;
        digits_d = 1'b0;
        closed_d = 1'b0;
        marker_d = '0;
        inter_d  = '0;
      end else if (cur_first && (byte_i >= MARK_LO) && (byte_i <= MARK_HI)) begin
        marker_d = byte_i;
      end else if (!closed_d) begin
        if ((byte_i >= CH_ZERO) && (byte_i <= CH_NINE)) begin
          if (prod > {4'b0, VMAX}) begin
            acc_d = VMAX;
          end else begin
            acc_d = prod[VALUE_BITS-1:0];
          end
          digits_d = 1'b1;
        end else if (byte_i == CH_COLON) begin
          if (sub_ok) begin
            push_o.count = 2'd1;
            push_o.first = elem;
            scnt_d       = cur_scnt + SCW'(1);
          end
          acc_d    = '0;
          digits_d = 1'b0;
        end else if (byte_i == CH_SEMI) begin
          if (!present || sub_ok) begin
            push_o.count = 2'd1;
            push_o.first = elem;
          end
          acc_d    = '0;
          digits_d = 1'b0;
          scnt_d   = '0;
          pcnt_d   = pcnt_inc[PCW-1:0];
          if (32'(pcnt_inc) >= 32'(MAX_PARAMS)) begin
            closed_d = 1'b1;
          end
        end else if ((byte_i >= INTER_LO) && (byte_i <= INTER_HI)) begin
          inter_d  = byte_i;
          closed_d = 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // A two-result beat is always an element followed by the closing command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> push_o.first.item_kind == KIND_ELEMENT
                          && push_o.second.item_kind == KIND_COMMAND)
    else $error("two results not ordered element then command");
  // After a command the parser is outside any sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count != 2'd0 && push_o.first.last) || push_o.count == 2'd2
      |=> !in_seq_q)
    else $error("sequence still open after command");
  // The parameter count never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pcnt_q) <= 32'(MAX_PARAMS))
    else $error("parameter count beyond limit");
`endif

endmodule

[hw/rtl/csi_result_queue.sv]
// Four-entry result queue that takes up to two results a cycle and hands
// out one per beat. Depends on csi_pkg.
module csi_result_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csi_pkg::push_t   push_i,
  input  logic             pop_i,
  output logic             valid_o,
  output csi_pkg::result_t head_o,
  output logic             room_o
);
  import csi_pkg::*;

  result_t        mem_q [QDEPTH];
  logic [QAW-1:0] rd_q, rd_d;
  logic [QAW-1:0] wr_q, wr_d;
  logic [QAW:0]   count_q, count_d;
  logic           pop;

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  assign room_o  = (32'(count_q) <= QDEPTH - 2);
  assign pop     = valid_o && pop_i;

  always_comb begin
    rd_d    = pop ? rd_q + QAW'(1) : rd_q;
    wr_d    = wr_q + QAW'(push_i.count);
    count_d = count_q + (QAW+1)'(push_i.count) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + QAW'(1)] <= push_i.second;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QDEPTH)
    else $error("result queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) + 32'(push_i.count) <= QDEPTH + 32'(pop))
    else $error("result queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.count == 2'd0 |=> count_q == $past(count_q) - (QAW+1)'(1))
    else $error("result queue count lost a beat");
`endif

endmodule

[verif/tb_csi_sequence_parser.sv]
// Testbench for csi_sequence_parser: drives sequence body bytes one beat at a
// time and checks every result beat against a predictor kept in the bench.
// Depends on csi_pkg, csi_if and the parser RTL.
`timescale 1ns / 100ps

module tb_csi_sequence_parser;
  import csi_pkg::*;

  localparam int MAX_PARAMS    = 16;
  localparam int VALUE_BITS    = 16;
  localparam int MAX_SUBPARAMS = 4;
  localparam int VALUE_MAX     = (1 << VALUE_BITS) - 1;
  localparam int END_SETTLE    = 16;
  localparam int LONG_STALL    = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  csi_in_if  in_if ();
  csi_out_if out_if ();

  csi_sequence_parser #(
    .MAX_PARAMS   (MAX_PARAMS),
    .VALUE_BITS   (VALUE_BITS),
    .MAX_SUBPARAMS(MAX_SUBPARAMS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic        seq_open;
  logic        first_pending;
  logic [4:0]  param_cnt;
  logic [2:0]  sub_cnt;
  int unsigned value_acc;
  logic        digit_seen;
  logic        params_done;
  logic [7:0]  marker_saved;
  logic [7:0]  inter_saved;

  result_t     parse_results_q[$];
  logic [8:0]  seq_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left = 0;
  int unsigned items_fed  = 0;
  int unsigned mismatch_cnt = 0;

  function automatic void clear_parse_state();
    first_pending = 1'b0;
    param_cnt     = '0;
    sub_cnt       = '0;
    value_acc     = 0;
    digit_seen    = 1'b0;
    params_done   = 1'b0;
    marker_saved  = '0;
    inter_saved   = '0;
  endfunction

  function automatic void push_element(input logic absent);
    result_t r;
    r = '0;
    r.item_kind    = KIND_ELEMENT;
    r.param_index  = param_cnt[3:0];
    r.sub_index    = sub_cnt;
    r.param_value  = absent ? 16'h0 : 16'(value_acc);
    r.param_absent = absent;
    parse_results_q.push_back(r);
  endfunction

  // Returns 1 when the byte was taken inside an open sequence.
  function automatic bit parse_byte(input logic [7:0] b, input logic sos);
    result_t     r;
    logic        first_now;
    logic        present;
    int unsigned d;
    if (sos) begin
      clear_parse_state();
      seq_open      = 1'b1;
      first_pending = 1'b1;
    end
    if (!seq_open) return 1'b0;
    first_now     = first_pending;
    first_pending = 1'b0;
    present       = digit_seen || (sub_cnt != 0);

    if (b >= FINAL_LO && b <= FINAL_HI) begin
      if (!params_done && present) begin
        if (sub_cnt <= MAX_SUBPARAMS) push_element(1'b0);
        param_cnt++;
      end
      r = '0;
      r.item_kind         = KIND_COMMAND;
      r.final_byte        = b[6:0];
      r.marker_byte       = marker_saved;
      r.intermediate_byte = inter_saved;
      r.param_count       = param_cnt;
      r.last              = 1'b1;
      parse_results_q.push_back(r);
      seq_open = 1'b0;
      clear_parse_state();
      return 1'b1;
    end
    if (first_now && b >= MARK_LO && b <= MARK_HI) begin
      marker_saved = b;
      return 1'b1;
    end
    if (params_done) return 1'b1;

    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = b - CH_ZERO;
      if (value_acc > (VALUE_MAX - d) / 10) value_acc = VALUE_MAX;
      else value_acc = value_acc * 10 + d;
      digit_seen = 1'b1;
    end else if (b == CH_COLON) begin
      if (sub_cnt <= MAX_SUBPARAMS) begin
        push_element(1'b0);
        sub_cnt++;
      end
      value_acc  = 0;
      digit_seen = 1'b0;
    end else if (b == CH_SEMI) begin
      if (!present) push_element(1'b1);
      else if (sub_cnt <= MAX_SUBPARAMS) push_element(1'b0);
      value_acc  = 0;
      digit_seen = 1'b0;
      sub_cnt    = '0;
      param_cnt++;
      if (param_cnt >= MAX_PARAMS) params_done = 1'b1;
    end else if (b >= INTER_LO && b <= INTER_HI) begin
      inter_saved = b;
      params_done = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d idx=%0d sub=%0d val=%0d abs=%0d fin=%h mk=%h im=%h cnt=%0d last=%0d",
                     r.item_kind, r.param_index, r.sub_index, r.param_value, r.param_absent,
                     r.final_byte, r.marker_byte, r.intermediate_byte, r.param_count, r.last);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t got_r;
    result_t exp_r;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got_r.item_kind         = out_if.item_kind;
      got_r.param_index       = out_if.param_index;
      got_r.sub_index         = out_if.sub_index;
      got_r.param_value       = out_if.param_value;
      got_r.param_absent      = out_if.param_absent;
      got_r.final_byte        = out_if.final_byte;
      got_r.marker_byte       = out_if.marker_byte;
      got_r.intermediate_byte = out_if.intermediate_byte;
      got_r.param_count       = out_if.param_count;
      got_r.last              = out_if.last;
      if (parse_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result: %s", fmt_result(got_r));
      end else begin
        exp_r = parse_results_q.pop_front();
        if (got_r.item_kind !== exp_r.item_kind || got_r.param_index !== exp_r.param_index ||
            got_r.sub_index !== exp_r.sub_index || got_r.param_value !== exp_r.param_value ||
            got_r.param_absent !== exp_r.param_absent ||
            got_r.final_byte !== exp_r.final_byte ||
            got_r.marker_byte !== exp_r.marker_byte ||
            got_r.intermediate_byte !== exp_r.intermediate_byte ||
            got_r.param_count !== exp_r.param_count || got_r.last !== exp_r.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(exp_r));
            $display("  actual   %s", fmt_result(got_r));
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.data_byte         <= b;
    in_if.start_of_sequence <= sos;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    if (parse_byte(b, sos)) items_fed++;
  endtask

  task automatic send_sequence();
    foreach (seq_q[i]) send_byte(seq_q[i][7:0], seq_q[i][8]);
  endtask

  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (parse_results_q.size() != 0);
  endtask

  function automatic void push_number();
    int unsigned pick;
    int unsigned n_digits;
    pick = $urandom_range(99);
    n_digits = (pick < 15) ? 0 : (pick < 85) ? $urandom_range(1, 3) : $urandom_range(4, 6);
    repeat (n_digits) seq_q.push_back({1'b0, CH_ZERO + 8'($urandom_range(9))});
  endfunction

  function automatic void build_sequence();
    int unsigned pick;
    int unsigned n_params;
    int unsigned n_subs;
    logic [7:0]  junk;
    seq_q.delete();
    pick = $urandom_range(99);
    if (pick < 5) begin
      repeat ($urandom_range(1, 4)) seq_q.push_back({1'b0, 8'($urandom_range(255))});
      return;
    end
    if (pick < 17) begin
      repeat ($urandom_range(1, 12))
        seq_q.push_back({1'($urandom_range(99) < 15), 8'($urandom_range(255))});
      seq_q[0][8] = 1'b1;
      return;
    end
    if ($urandom_range(99) < 25) seq_q.push_back({1'b0, MARK_LO + 8'($urandom_range(3))});
    pick = $urandom_range(99);
    n_params = (pick < 70) ? $urandom_range(4) :
               (pick < 92) ? $urandom_range(5, 10) : $urandom_range(14, 19);
    for (int p = 0; p < n_params; p++) begin
      if (p != 0) seq_q.push_back({1'b0, CH_SEMI});
      push_number();
      n_subs = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 6);
      repeat (n_subs) begin
        seq_q.push_back({1'b0, CH_COLON});
        push_number();
      end
    end
    if ($urandom_range(99) < 10) seq_q.push_back({1'b0, CH_SEMI});
    if ($urandom_range(99) < 20) begin
      seq_q.push_back({1'b0, INTER_LO + 8'($urandom_range(15))});
      repeat ($urandom_range(2)) seq_q.push_back({1'b0, INTER_LO + 8'($urandom_range(31))});
    end
    if ($urandom_range(99) < 10) begin
      junk = 8'($urandom_range(255));
      if (junk >= FINAL_LO && junk <= FINAL_HI) junk = junk ^ 8'h80;
      seq_q.insert($urandom_range(seq_q.size()), {1'b0, junk});
    end
    seq_q.push_back({1'b0, FINAL_LO + 8'($urandom_range(63))});
    seq_q[0][8] = 1'b1;
  endfunction

  task automatic test_stray_bytes();
    send_byte(8'h41, 1'b0);
    send_byte(FINAL_LO, 1'b1);
  endtask

  task automatic test_field_limits();
    send_byte(8'h33, 1'b1);
    send_byte(MARK_HI, 1'b1);
    send_byte(8'h36, 1'b0);
    send_byte(8'h35, 1'b0);
    send_byte(8'h35, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h36, 1'b0);
    repeat (5) send_byte(CH_COLON, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(8'h3D, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SEMI, 1'b0);
    send_byte(CH_SEMI, 1'b0);
    send_byte(INTER_HI, 1'b0);
    send_byte(CH_NINE, 1'b0);
    send_byte(FINAL_HI, 1'b0);
  endtask

  task automatic test_param_limit();
    send_byte(CH_SEMI, 1'b1);
    repeat (MAX_PARAMS - 1) send_byte(CH_SEMI, 1'b0);
    send_byte(CH_ZERO, 1'b0);
    send_byte(8'h6D, 1'b0);
  endtask

  task automatic test_backpressure();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    stall_left = LONG_STALL;
    @(posedge clk_i);
    send_byte(8'h31, 1'b1);
    repeat (12) begin
      send_byte(CH_SEMI, 1'b0);
      send_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    end
    send_byte(8'h6D, 1'b0);
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      build_sequence();
      send_sequence();
      wait_results_done();
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned target;
    target = items_fed + n_items;
    while (items_fed < target) begin
      build_sequence();
      send_sequence();
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    in_if.valid             = 1'b0;
    in_if.data_byte         = '0;
    in_if.start_of_sequence = 1'b0;
    out_if.ready            = 1'b0;
    seq_open                = 1'b0;
    clear_parse_state();
    send_idle_pct = 12;
    recv_idle_pct = 70;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_bytes();
    test_field_limits();
    test_param_limit();
    test_backpressure();
    test_drain_pause();
    run_random(450);

    send_idle_pct = 70;
    recv_idle_pct = 12;
    run_random(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    run_random(450);

    wait_results_done();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[csi_sequence_parser] OK");
    end else begin
      $display("[csi_sequence_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[csi_sequence_parser] ERROR");
    $finish;
  end

endmodule
